// ----- rtl/qrs_pkg.sv -----
`timescale 1ns / 1ps

package qrs_pkg;

  // Field widths
  localparam int COEF_W = 16;
  localparam int THR_W  = 16;
  localparam int Q_W    = 32;
  localparam int CNT_W  = 2;

  // Discriminant b*b - 4*a*c, and the positive radicand handed to the square root
  localparam int PROD_W = 2 * COEF_W;
  localparam int DISC_W = PROD_W + 2;
  localparam int RAD_W  = DISC_W - 1;
  localparam int FRAC_W = 16;

  // Square root of rad << 16: one result bit per stage
  localparam int ROOT_W  = (RAD_W + FRAC_W + 1) / 2;
  localparam int SQ_IN_W = 2 * ROOT_W;
  localparam int ISQ_LAT = ROOT_W;

  // Rounding divider: signed numerator, signed coefficient divisor
  localparam int NUM_W   = 34;
  localparam int DIV_N_W = NUM_W;
  localparam int DIV_D_W = COEF_W + 1;
  localparam int DIV_LAT = DIV_N_W + 2;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef logic [CNT_W-1:0] count_t;
  localparam count_t CNT_NONE = 2'd0;
  localparam count_t CNT_ONE  = 2'd1;
  localparam count_t CNT_TWO  = 2'd2;
  localparam count_t CNT_INF  = 2'd3;

  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_INF,
    MODE_LIN,
    MODE_DBL,
    MODE_TWO
  } mode_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
  } side_t;

  typedef struct packed {
    count_t                count;
    logic signed [Q_W-1:0] r1;
    logic signed [Q_W-1:0] r2;
    logic                  ov;
  } res_t;

  // Magnitude of a coefficient; the most negative value maps to 2^15
  function automatic logic [COEF_W-1:0] mag16(input logic signed [COEF_W-1:0] x);
    logic signed [COEF_W-1:0] n;
    n = -x;
    return x[COEF_W-1] ? n : x;
  endfunction

endpackage

// ----- rtl/qrs_if.sv -----
`timescale 1ns / 1ps

interface qrs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] coef_quadratic;
  logic signed [15:0] coef_linear;
  logic signed [15:0] coef_constant;

  modport source (output valid, coef_quadratic, coef_linear, coef_constant, input ready);
  modport sink (input valid, coef_quadratic, coef_linear, coef_constant, output ready);
endinterface

interface qrs_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         root_count;
  logic signed [31:0] root_one;
  logic signed [31:0] root_two;
  logic               overflow;

  modport source (output valid, root_count, root_one, root_two, overflow, input ready);
  modport sink (input valid, root_count, root_one, root_two, overflow, output ready);
endinterface

// ----- rtl/qrs_front.sv -----
`timescale 1ns / 1ps

module qrs_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [qrs_pkg::COEF_W-1:0] a,
  input  logic signed [qrs_pkg::COEF_W-1:0] b,
  input  logic signed [qrs_pkg::COEF_W-1:0] c,
  input  logic [qrs_pkg::THR_W-1:0]         thr,
  output logic                              out_valid,
  output qrs_pkg::side_t                    side,
  output logic [qrs_pkg::RAD_W-1:0]         rad
);
  import qrs_pkg::*;

  localparam int SH_W = COEF_W + 8;

  logic                     v0, v1, v2;
  logic signed [COEF_W-1:0] a0, b0, c0, a1, b1, c1;
  logic signed [PROD_W-1:0] bb, ac;
  logic                     az, bz, cz;
  logic                     az_next, bz_next, cz_next;
  logic signed [DISC_W-1:0] disc;
  logic [DISC_W-1:0]        dmag;
  logic                     dz;
  mode_t                    mode_next;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  // Capture coefficients
  always_ff @(posedge clk) begin
    if (en) begin
      a0 <= a;
      b0 <= b;
      c0 <= c;
    end
  end

  // Zero tests on coefficients, scaled to Q16.16
  assign az_next = {mag16(a0), 8'b0} < SH_W'(thr);
  assign bz_next = {mag16(b0), 8'b0} < SH_W'(thr);
  assign cz_next = {mag16(c0), 8'b0} < SH_W'(thr);

  // Products and flags
  always_ff @(posedge clk) begin
    if (en) begin
      bb <= b0 * b0;
      ac <= a0 * c0;
      az <= az_next;
      bz <= bz_next;
      cz <= cz_next;
      a1 <= a0;
      b1 <= b0;
      c1 <= c0;
    end
  end

  // Discriminant and case selection; an exact zero that is not below the
  // threshold gives no root
  always_comb begin
    disc = {{2{bb[PROD_W-1]}}, bb} - {ac, 2'b00};
    dmag = disc[DISC_W-1] ? DISC_W'(-disc) : DISC_W'(disc);
    dz   = dmag < DISC_W'(thr);
    if (az) begin
      if (bz) begin
        mode_next = cz ? MODE_INF : MODE_NONE;
      end else begin
        mode_next = MODE_LIN;
      end
    end else if (dz) begin
      mode_next = MODE_DBL;
    end else if (!disc[DISC_W-1] && (disc != '0)) begin
      mode_next = MODE_TWO;
    end else begin
      mode_next = MODE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side.mode <= mode_next;
      side.a    <= a1;
      side.b    <= b1;
      side.c    <= c1;
      rad       <= (mode_next == MODE_TWO) ? disc[RAD_W-1:0] : '0;
    end
  end

  assign out_valid = v2;

endmodule

// ----- rtl/qrs_isqrt.sv -----
`timescale 1ns / 1ps

module qrs_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [qrs_pkg::RAD_W-1:0]  rad,
  output logic                       out_valid,
  output logic [qrs_pkg::ROOT_W-1:0] root
);
  import qrs_pkg::*;

  localparam int REM_W = ROOT_W + 1;

  logic [ISQ_LAT-1:0] vld;
  logic [REM_W-1:0]   rem_s  [ISQ_LAT];
  logic [ROOT_W-1:0]  root_s [ISQ_LAT];
  logic [SQ_IN_W-1:0] x_s    [ISQ_LAT];
  logic [SQ_IN_W-1:0] x0;

  assign x0 = SQ_IN_W'({rad, {FRAC_W{1'b0}}});

  // One root bit per stage, most significant pair of radicand bits first
  for (genvar i = 0; i < ISQ_LAT; i++) begin : g_stage
    localparam int P = ISQ_LAT - 1 - i;
    logic [REM_W-1:0]   rem_in;
    logic [ROOT_W-1:0]  root_in;
    logic [SQ_IN_W-1:0] x_in;
    logic               v_in;
    logic [REM_W+1:0]   r;
    logic [REM_W+1:0]   t;
    logic               ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x0;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem_s[i-1];
      assign root_in = root_s[i-1];
      assign x_in    = x_s[i-1];
      assign v_in    = vld[i-1];
    end

    assign r  = {rem_in, x_in[2*P+1 -: 2]};
    assign t  = (REM_W + 2)'({root_in, 2'b01});
    assign ge = r >= t;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i]  <= ge ? REM_W'(r - t) : REM_W'(r);
        root_s[i] <= {root_in[ROOT_W-2:0], ge};
        x_s[i]    <= x_in;
      end
    end
  end

  assign out_valid = vld[ISQ_LAT-1];
  assign root      = root_s[ISQ_LAT-1];

endmodule

// ----- rtl/qrs_div.sv -----
`timescale 1ns / 1ps

module qrs_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [qrs_pkg::NUM_W-1:0]  num,
  input  logic signed [qrs_pkg::COEF_W-1:0] den,
  output logic                              out_valid,
  output logic signed [qrs_pkg::Q_W-1:0]    quo,
  output logic                              ov
);
  import qrs_pkg::*;

  localparam int STG = DIV_N_W;

  logic [NUM_W-1:0]   un;
  logic [COEF_W-1:0]  ud;
  logic               pv;
  logic [DIV_N_W-1:0] pn;
  logic [DIV_D_W-1:0] pd;
  logic               pneg, pnneg, pdz;

  logic [STG-1:0]     vld;
  logic [DIV_D_W-1:0] rem_s  [STG];
  logic [DIV_N_W-1:0] n_s    [STG];
  logic [DIV_N_W-1:0] q_s    [STG];
  logic [DIV_D_W-1:0] d_s    [STG];
  logic [2:0]         f_s    [STG];

  logic [DIV_N_W-1:0]    qf;
  logic                  fneg, fnneg, fdz;
  logic signed [Q_W-1:0] quo_next;
  logic                  ov_next;
  logic                  fv;

  // Prepare magnitudes: N = 2|n| + |d|, D = 2|d| gives a rounded quotient
  assign un = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign ud = mag16(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pn    <= {un[DIV_N_W-2:0], 1'b0} + DIV_N_W'(ud);
      pd    <= {ud, 1'b0};
      pneg  <= num[NUM_W-1] ^ den[COEF_W-1];
      pnneg <= num[NUM_W-1];
      pdz   <= (den == '0);
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar k = 0; k < STG; k++) begin : g_stage
    localparam int J = DIV_N_W - 1 - k;
    logic [DIV_D_W-1:0] rem_in;
    logic [DIV_N_W-1:0] n_in;
    logic [DIV_N_W-1:0] q_in;
    logic [DIV_D_W-1:0] d_in;
    logic [2:0]         f_in;
    logic               v_in;
    logic [DIV_D_W:0]   r;
    logic               ge;
    logic [DIV_N_W-1:0] q_out;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign n_in   = pn;
      assign q_in   = '0;
      assign d_in   = pd;
      assign f_in   = {pneg, pnneg, pdz};
      assign v_in   = pv;
    end else begin : g_next
      assign rem_in = rem_s[k-1];
      assign n_in   = n_s[k-1];
      assign q_in   = q_s[k-1];
      assign d_in   = d_s[k-1];
      assign f_in   = f_s[k-1];
      assign v_in   = vld[k-1];
    end

    assign r  = {rem_in, n_in[J]};
    assign ge = r >= {1'b0, d_in};

    always_comb begin
      q_out    = q_in;
      q_out[J] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k] <= ge ? DIV_D_W'(r - {1'b0, d_in}) : DIV_D_W'(r);
        n_s[k]   <= n_in;
        q_s[k]   <= q_out;
        d_s[k]   <= d_in;
        f_s[k]   <= f_in;
      end
    end
  end

  // Apply sign and clamp to the Q16.16 range
  assign qf    = q_s[STG-1];
  assign fneg  = f_s[STG-1][2];
  assign fnneg = f_s[STG-1][1];
  assign fdz   = f_s[STG-1][0];
  assign fv    = vld[STG-1];

  always_comb begin
    if (fdz) begin
      quo_next = fnneg ? Q_MIN : Q_MAX;
      ov_next  = 1'b1;
    end else if (fneg) begin
      if (qf > DIV_N_W'({1'b1, {(Q_W-1){1'b0}}})) begin
        quo_next = Q_MIN;
        ov_next  = 1'b1;
      end else begin
        quo_next = Q_W'(-qf);
        ov_next  = 1'b0;
      end
    end else begin
      if (qf > DIV_N_W'(Q_MAX)) begin
        quo_next = Q_MAX;
        ov_next  = 1'b1;
      end else begin
        quo_next = Q_W'(qf);
        ov_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= fv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= quo_next;
      ov  <= ov_next;
    end
  end

endmodule

// ----- rtl/quadratic_root_solver_top.sv -----
`timescale 1ns / 1ps

// Quadratic root solver: a*x^2 + b*x + c with signed Q8.8 coefficients,
// real roots in signed Q16.16 with a root count and a saturation flag.
//
// coef_in carries one equation per item (valid/ready); root_out carries one
// result per item, in order. cfg_we/cfg_wdata write the Q16.16 zero threshold
// (reset value 1); write it only while no item is in flight.
//
// Throughput: one item per cycle while the skid register is empty. Path from
// acceptance to root_out.valid: 3 front stages for products and discriminant,
// 25 square root stages, one numerator stage, 36 rounding divider stages, one
// output register. Two divider pipelines run side by side for the two roots.
//
// Reset (rst, synchronous) empties the pipeline and sets the threshold to 1.
// When root_out stalls, the held result stays on the port and one more result
// lands in a skid register; coef_in.ready then drops and the whole pipeline
// freezes until the skid register drains. No item is lost or repeated.
module quadratic_root_solver_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [qrs_pkg::THR_W-1:0]        cfg_wdata,
  qrs_in_if.sink                           coef_in,
  qrs_out_if.source                        root_out
);
  import qrs_pkg::*;

  logic [THR_W-1:0] thr;
  logic             en;

  logic             fv;
  side_t            fside;
  logic [RAD_W-1:0] frad;

  logic              sv;
  logic [ROOT_W-1:0] sroot;
  side_t             sd [ISQ_LAT];

  logic                     nv;
  logic signed [NUM_W-1:0]  n1, n2, n1_next, n2_next;
  logic signed [COEF_W-1:0] den, den_next;
  mode_t                    nmode;

  logic signed [24:0]      nb;
  logic signed [26:0]      sx, sum, dif;
  logic signed [31:0]      cs;
  logic signed [30:0]      bs;

  logic                  d1v, d2v;
  logic signed [Q_W-1:0] q1, q2;
  logic                  o1, o2;
  mode_t                 md [DIV_LAT];

  logic pv;
  res_t pd;
  logic ovld, skid_valid;
  res_t odata, sdata;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_W'(1);
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  // Pipeline advances unless the skid register holds a result
  assign en            = !skid_valid;
  assign coef_in.ready = en;

  qrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (coef_in.valid),
    .a         (coef_in.coef_quadratic),
    .b         (coef_in.coef_linear),
    .c         (coef_in.coef_constant),
    .thr       (thr),
    .out_valid (fv),
    .side      (fside),
    .rad       (frad)
  );

  qrs_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fv),
    .rad       (frad),
    .out_valid (sv),
    .root      (sroot)
  );

  // Carry the case and coefficients alongside the square root
  for (genvar i = 0; i < ISQ_LAT; i++) begin : g_sd
    always_ff @(posedge clk) begin
      if (en) begin
        sd[i] <= (i == 0) ? fside : sd[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // Form numerators and divisor for the selected case
  always_comb begin
    nb  = -{sd[ISQ_LAT-1].b[COEF_W-1], sd[ISQ_LAT-1].b, 8'b0};
    sx  = {2'b00, sroot};
    sum = {{2{nb[24]}}, nb} + sx;
    dif = {{2{nb[24]}}, nb} - sx;
    cs  = {sd[ISQ_LAT-1].c, 16'b0};
    bs  = {sd[ISQ_LAT-1].b, 15'b0};
    n1_next  = '0;
    n2_next  = '0;
    den_next = sd[ISQ_LAT-1].a;
    case (sd[ISQ_LAT-1].mode)
      MODE_LIN: begin
        n1_next  = -{{2{cs[31]}}, cs};
        den_next = sd[ISQ_LAT-1].b;
      end
      MODE_DBL: begin
        n1_next = -{{3{bs[30]}}, bs};
      end
      MODE_TWO: begin
        n1_next = {sum, 7'b0};
        n2_next = {dif, 7'b0};
      end
      default: begin
        n1_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nv <= 1'b0;
    end else if (en) begin
      nv <= sv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1    <= n1_next;
      n2    <= n2_next;
      den   <= den_next;
      nmode <= sd[ISQ_LAT-1].mode;
    end
  end

  qrs_div u_div1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (nv),
    .num       (n1),
    .den       (den),
    .out_valid (d1v),
    .quo       (q1),
    .ov        (o1)
  );

  qrs_div u_div2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (nv),
    .num       (n2),
    .den       (den),
    .out_valid (d2v),
    .quo       (q2),
    .ov        (o2)
  );

  // Carry the case alongside the dividers
  for (genvar i = 0; i < DIV_LAT; i++) begin : g_md
    always_ff @(posedge clk) begin
      if (en) begin
        md[i] <= (i == 0) ? nmode : md[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // Assemble the result; absent roots read zero
  assign pv = d1v;

  always_comb begin
    pd.count = CNT_NONE;
    pd.r1    = '0;
    pd.r2    = '0;
    pd.ov    = 1'b0;
    unique case (md[DIV_LAT-1])
      MODE_NONE: pd.count = CNT_NONE;
      MODE_INF:  pd.count = CNT_INF;
      MODE_LIN, MODE_DBL: begin
        pd.count = CNT_ONE;
        pd.r1    = q1;
        pd.ov    = o1;
      end
      MODE_TWO: begin
        pd.count = CNT_TWO;
        pd.r1    = q1;
        pd.r2    = q2;
        pd.ov    = o1 | o2;
      end
      default: pd.count = CNT_NONE;
    endcase
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ovld       <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!ovld || root_out.ready) begin
      if (skid_valid) begin
        ovld       <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        ovld <= pv;
      end
    end else if (pv && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ovld || root_out.ready) begin
      odata <= skid_valid ? sdata : pd;
    end else if (pv && en) begin
      sdata <= pd;
    end
  end

  assign root_out.valid      = ovld;
  assign root_out.root_count = odata.count;
  assign root_out.root_one   = odata.r1;
  assign root_out.root_two   = odata.r2;
  assign root_out.overflow   = odata.ov;

`ifndef ASSERT_OFF
  // Both divider pipelines stay in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst) d1v == d2v)
    else $error("divider pipelines out of step");

  // Skid register only fills behind a held result
  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> ovld)
    else $error("skid holds a result with empty output register");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(ovld && !root_out.ready))
    else $error("skid filled without a stall");

  // No roots or infinitely many roots means zero root values and no overflow
  a_no_root: assert property (@(posedge clk) disable iff (rst)
    ovld && (odata.count == CNT_NONE || odata.count == CNT_INF)
      |-> odata.r1 == '0 && odata.r2 == '0 && !odata.ov)
    else $error("root reported without a root count");
`endif

endmodule
